FILE: sv/tgf_pkg.sv
// Shared types and event codes for the touch ghost-frame filter.
package tgf_pkg;

    localparam logic [15:0] TYPE_SYN    = 16'h0000;
    localparam logic [15:0] TYPE_ABS    = 16'h0003;
    localparam logic [15:0] CODE_REPORT = 16'h0000;
    localparam logic [15:0] CODE_SLOT   = 16'h002f;
    localparam logic [15:0] CODE_TRACK  = 16'h0039;
    localparam logic [15:0] CODE_X      = 16'h0035;
    localparam logic [15:0] CODE_Y      = 16'h0036;
    localparam logic [15:0] CODE_TMAJOR = 16'h0030;
    localparam logic [15:0] CODE_WMAJOR = 16'h0032;
    localparam logic [15:0] CODE_PRESS  = 16'h003a;

    localparam logic [31:0] TRACK_LIFT  = 32'hffff_ffff;

    localparam int WORD_W  = 64;
    localparam int STAMP_W = 52;

    // One classified event on its way from the front to the back.
    typedef struct packed {
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [31:0] ev_value;
        logic [31:0] seconds;
        logic [19:0] micro;
        logic        is_report;
        logic        pass;
    } t_cmd;

endpackage

FILE: sv/tgf_front.sv
// Front end: accepts events, tracks per-slot contact marks, judges frames.
module tgf_front #(
    parameter int SLOT_COUNT = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [15:0]        i_event_type,
    input  logic [15:0]        i_event_code,
    input  logic signed [31:0] i_event_value,
    input  logic [31:0]        i_time_seconds,
    input  logic [19:0]        i_time_micro,
    output logic               o_cmd_push,
    output tgf_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_full
);
    import tgf_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [SLOT_COUNT-1:0] r_active, n_active;
    logic [SLOT_COUNT-1:0] r_known, n_known;
    logic [SLOT_COUNT-1:0] r_press, n_press;
    logic [SLOT_COUNT-1:0] r_xseen, n_xseen;
    logic [SLOT_COUNT-1:0] r_yseen, n_yseen;
    logic [SLOT_W-1:0]     r_slot, n_slot;

    logic        accept;
    logic        is_abs;
    logic        is_report;
    logic [31:0] uval;

    assign o_full     = i_cmd_full;
    assign accept     = i_push && !i_cmd_full;
    assign o_cmd_push = accept;
    assign is_abs     = (i_event_type == TYPE_ABS);
    assign is_report  = (i_event_type == TYPE_SYN) && (i_event_code == CODE_REPORT);
    assign uval       = i_event_value;

    always_comb begin
        o_cmd.ev_type   = i_event_type;
        o_cmd.ev_code   = i_event_code;
        o_cmd.ev_value  = uval;
        o_cmd.seconds   = i_time_seconds;
        o_cmd.micro     = i_time_micro;
        o_cmd.is_report = is_report;
        // drop the frame if any live contact shows pressure with no position
        o_cmd.pass      = ~|(r_active & r_press & ~r_known);
    end

    always_comb begin
        n_active = r_active;
        n_known  = r_known;
        n_press  = r_press;
        n_xseen  = r_xseen;
        n_yseen  = r_yseen;
        n_slot   = r_slot;
        if (accept && is_abs) begin
            unique case (i_event_code)
                CODE_SLOT: begin
                    n_slot = (uval < 32'(SLOT_COUNT)) ? uval[SLOT_W-1:0] : '0;
                end
                CODE_TRACK: begin
                    if (uval == TRACK_LIFT) begin
                        n_active[r_slot] = 1'b0;
                        n_known[r_slot]  = 1'b0;
                    end else begin
                        n_active[r_slot] = 1'b1;
                    end
                end
                CODE_X: begin
                    n_xseen[r_slot] = 1'b1;
                    if (r_yseen[r_slot]) n_known[r_slot] = 1'b1;
                end
                CODE_Y: begin
                    n_yseen[r_slot] = 1'b1;
                    if (r_xseen[r_slot]) n_known[r_slot] = 1'b1;
                end
                CODE_TMAJOR, CODE_WMAJOR, CODE_PRESS: begin
                    n_press[r_slot] = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (accept && is_report) begin
            n_press = '0;
            n_xseen = '0;
            n_yseen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_known  <= '0;
            r_press  <= '0;
            r_xseen  <= '0;
            r_yseen  <= '0;
            r_slot   <= '0;
        end else begin
            r_active <= n_active;
            r_known  <= n_known;
            r_press  <= n_press;
            r_xseen  <= n_xseen;
            r_yseen  <= n_yseen;
            r_slot   <= n_slot;
        end
    end

endmodule

FILE: sv/tgf_cmd_queue.sv
// Two-entry queue of classified events between the front and the back.
module tgf_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tgf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output tgf_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import tgf_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = do_push ? ~r_wp : r_wp;
        n_rp  = do_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: sv/tgf_back.sv
// Back end: buffers a frame's events and replays passing frames.
module tgf_back #(
    parameter int FRAME_EVENTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tgf_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [15:0]   o_out_type,
    output logic [15:0]   o_out_code,
    output logic [31:0]   o_out_value,
    output logic [31:0]   o_out_seconds,
    output logic [19:0]   o_out_micro,
    output logic          o_last_in_frame
);
    import tgf_pkg::*;

    localparam int FILL_W = $clog2(FRAME_EVENTS + 1);
    localparam int IDX_W  = $clog2(FRAME_EVENTS);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REPLAY = 1'b1;

    logic [WORD_W-1:0]  mem_word  [FRAME_EVENTS];
    logic [STAMP_W-1:0] mem_stamp [FRAME_EVENTS];

    logic              r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_total, n_total;
    logic [FILL_W-1:0] r_rd, n_rd;
    logic              r_out_valid, n_out_valid;
    logic              r_out_last;
    logic [WORD_W-1:0]  r_out_word;
    logic [STAMP_W-1:0] r_out_stamp;

    logic              take;
    logic              room;
    logic              issue;
    logic [FILL_W-1:0] frame_n;

    assign take      = (r_state == ST_IDLE) && !i_cmd_empty;
    assign o_cmd_pop = take;
    assign room      = (r_fill < FILL_W'(FRAME_EVENTS));
    assign frame_n   = r_fill + FILL_W'(room);
    // load the output register when it is free or being drained this cycle
    assign issue     = (r_state == ST_REPLAY) && (!r_out_valid || i_pop);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_total     = r_total;
        n_rd        = r_rd;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_pop) n_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_fill = frame_n;
                    if (i_cmd.is_report) begin
                        n_fill = '0;
                        if (i_cmd.pass && (frame_n != '0)) begin
                            n_total = frame_n;
                            n_rd    = '0;
                            n_state = ST_REPLAY;
                        end
                    end
                end
            end
            ST_REPLAY: begin
                if (issue) begin
                    n_out_valid = 1'b1;
                    n_rd        = r_rd + FILL_W'(1);
                    if (r_rd + FILL_W'(1) == r_total) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take && room) begin
            mem_word[r_fill[IDX_W-1:0]]  <= {i_cmd.ev_type, i_cmd.ev_code, i_cmd.ev_value};
            mem_stamp[r_fill[IDX_W-1:0]] <= {i_cmd.seconds, i_cmd.micro};
        end
        if (issue) begin
            r_out_word  <= mem_word[r_rd[IDX_W-1:0]];
            r_out_stamp <= mem_stamp[r_rd[IDX_W-1:0]];
            r_out_last  <= (r_rd + FILL_W'(1) == r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_rd        <= n_rd;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_out_type      = r_out_word[63:48];
    assign o_out_code      = r_out_word[47:32];
    assign o_out_value     = r_out_word[31:0];
    assign o_out_seconds   = r_out_stamp[51:20];
    assign o_out_micro     = r_out_stamp[19:0];
    assign o_last_in_frame = r_out_last;

endmodule

FILE: sv/touch_ghost_frame_filter.sv
// Top level of the multitouch ghost-frame filter.
//
// Input channel: drive an event on the i_ fields with i_push; it is taken at
// an edge where i_push is high and o_full is low. The front end updates the
// per-slot contact marks in that cycle and passes the event through a
// two-entry queue to the back end, which stores it in the frame buffer
// (FRAME_EVENTS entries; events past a full buffer are not stored).
// A report event closes the frame: if no active slot shows pressure without a
// known position, the stored events are replayed in order, the last one
// flagged by o_last_in_frame; otherwise the frame is dropped silently.
// Result channel: the oldest result sits on the o_ fields while o_empty is
// low and is taken at an edge where i_pop is high.
// Rate: one event per cycle while the back end is storing. A replay reads one
// buffer entry per cycle into the output register, so results follow one per
// cycle while i_pop stays high; the first result is read once the back end
// has taken the report. During a replay the back end takes no new events, and
// once the queue fills o_full rises. A stalled receiver holds the replay.
// Reset (synchronous, i_rst_n low) clears all slot marks, the slot pointer,
// the queue and the buffer fill; buffer contents are left as they are.
module touch_ghost_frame_filter #(
    parameter int SLOT_COUNT   = 10,
    parameter int FRAME_EVENTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [15:0]        i_event_type,
    input  logic [15:0]        i_event_code,
    input  logic signed [31:0] i_event_value,
    input  logic [31:0]        i_time_seconds,
    input  logic [19:0]        i_time_micro,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [15:0]        o_out_type,
    output logic [15:0]        o_out_code,
    output logic signed [31:0] o_out_value,
    output logic [31:0]        o_out_seconds,
    output logic [19:0]        o_out_micro,
    output logic               o_last_in_frame
);
    import tgf_pkg::*;

    t_cmd        front_cmd;
    t_cmd        back_cmd;
    logic        front_push;
    logic        q_full;
    logic        q_empty;
    logic        back_pop;
    logic [31:0] out_value;

    tgf_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_event_type   (i_event_type),
        .i_event_code   (i_event_code),
        .i_event_value  (i_event_value),
        .i_time_seconds (i_time_seconds),
        .i_time_micro   (i_time_micro),
        .o_cmd_push     (front_push),
        .o_cmd          (front_cmd),
        .i_cmd_full     (q_full)
    );

    tgf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_cmd   (back_cmd),
        .o_empty (q_empty)
    );

    tgf_back #(
        .FRAME_EVENTS (FRAME_EVENTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (back_cmd),
        .i_cmd_empty     (q_empty),
        .o_cmd_pop       (back_pop),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_out_type      (o_out_type),
        .o_out_code      (o_out_code),
        .o_out_value     (out_value),
        .o_out_seconds   (o_out_seconds),
        .o_out_micro     (o_out_micro),
        .o_last_in_frame (o_last_in_frame)
    );

    assign o_out_value = signed'(out_value);

endmodule

FILE: tb/sv/tb_touch_ghost_frame_filter.sv
// Self-checking testbench for the touch ghost-frame filter: directed table, then random frames and events.
module tb_touch_ghost_frame_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import tgf_pkg::*;

    localparam int SLOTS            = 10;
    localparam int FRAME_DEPTH      = 64;
    localparam int RANDOM_EVENTS    = 446;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_OFF_AFTER   = 40;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int CALM_FROM        = 250;
    localparam int CALM_TO          = 360;
    localparam int DRAIN_CYCLES     = 40;
    localparam int MAX_PRINTED      = 40;
    localparam logic [7:0] BY_PREDICTOR = 8'hff;
    localparam logic [15:0] CODE_OTHER  = 16'h1234;

    typedef struct packed {
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [31:0] ev_value;
        logic [31:0] secs;
        logic [19:0] micro;
    } touch_event_t;

    typedef struct packed {
        touch_event_t ev;
        logic         last;
    } replay_t;

    typedef struct packed {
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [31:0] ev_value;
        logic [31:0] secs;
        logic [19:0] micro;
        logic [7:0]  replay_n;
    } directed_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    logic               o_full;
    logic [15:0]        i_event_type;
    logic [15:0]        i_event_code;
    logic signed [31:0] i_event_value;
    logic [31:0]        i_time_seconds;
    logic [19:0]        i_time_micro;
    logic               o_empty;
    logic               i_pop;
    logic [15:0]        o_out_type;
    logic [15:0]        o_out_code;
    logic signed [31:0] o_out_value;
    logic [31:0]        o_out_seconds;
    logic [19:0]        o_out_micro;
    logic               o_last_in_frame;

    // contact marks and frame buffer as the block should hold them
    bit           contact_active  [SLOTS];
    bit           contact_located [SLOTS];
    bit           contact_pressed [SLOTS];
    bit           x_this_frame    [SLOTS];
    bit           y_this_frame    [SLOTS];
    int unsigned  slot_ptr;
    touch_event_t frame_store [$];
    replay_t      replay_expect [$];
    int           last_replay_count;

    int           mismatches;
    int           events_taken;
    int unsigned  cycle_count;
    replay_t      want;

    directed_row_t steer_table [24] = '{
        // lone report after reset: replays itself, extreme stamps
        '{TYPE_SYN, CODE_REPORT, 32'h7fff_ffff, 32'hffff_ffff, 20'hf_ffff, 8'd1},
        '{TYPE_ABS, CODE_SLOT,   32'd3,         32'd0,         20'd0,      BY_PREDICTOR},
        '{TYPE_ABS, CODE_TRACK,  32'd100,       32'd1,         20'd1,      BY_PREDICTOR},
        '{TYPE_ABS, CODE_PRESS,  32'd50,        32'd2,         20'd999999, BY_PREDICTOR},
        // pressure on an active slot with no position: drop
        '{TYPE_SYN, CODE_REPORT, 32'd0,         32'd3,         20'd3,      8'd0},
        '{TYPE_ABS, CODE_X,      32'h8000_0000, 32'd4,         20'd5,      BY_PREDICTOR},
        '{TYPE_ABS, CODE_Y,      32'h7fff_ffff, 32'd5,         20'd6,      BY_PREDICTOR},
        '{TYPE_ABS, CODE_TMAJOR, 32'd9,         32'd6,         20'd7,      BY_PREDICTOR},
        '{TYPE_SYN, CODE_REPORT, 32'd0,         32'd7,         20'd8,      8'd4},
        // negative and too-large slot both select slot 0
        '{TYPE_ABS, CODE_SLOT,   32'hffff_ffff, 32'h8000_0000, 20'h8_0000, BY_PREDICTOR},
        '{TYPE_ABS, CODE_SLOT,   32'd10,        32'h7fff_ffff, 20'h7_ffff, BY_PREDICTOR},
        '{TYPE_ABS, CODE_TRACK,  32'd7,         32'd11,        20'd11,     BY_PREDICTOR},
        '{TYPE_ABS, CODE_WMAJOR, 32'd1,         32'd12,        20'd12,     BY_PREDICTOR},
        '{16'hffff, 16'hffff,    32'h8000_0000, 32'd13,        20'd13,     BY_PREDICTOR},
        '{TYPE_SYN, 16'hffff,    32'd0,         32'd14,        20'd14,     BY_PREDICTOR},
        '{TYPE_SYN, CODE_REPORT, 32'd0,         32'd15,        20'd15,     8'd0},
        // lift slot 0, then pressure on it no longer counts
        '{TYPE_ABS, CODE_TRACK,  32'hffff_ffff, 32'd16,        20'd16,     BY_PREDICTOR},
        '{TYPE_ABS, CODE_PRESS,  32'd3,         32'd17,        20'd17,     BY_PREDICTOR},
        '{TYPE_ABS, CODE_X,      32'd1,         32'd18,        20'd18,     BY_PREDICTOR},
        '{TYPE_SYN, CODE_REPORT, 32'hdead_beef, 32'd19,        20'd19,     8'd4},
        '{TYPE_ABS, CODE_SLOT,   32'd9,         32'd20,        20'd20,     BY_PREDICTOR},
        '{TYPE_ABS, CODE_TRACK,  32'd0,         32'd21,        20'd21,     BY_PREDICTOR},
        '{TYPE_ABS, CODE_PRESS,  32'd1,         32'd22,        20'd22,     BY_PREDICTOR},
        '{TYPE_SYN, CODE_REPORT, 32'd0,         32'd23,        20'd23,     8'd0}
    };

    touch_ghost_frame_filter #(
        .SLOT_COUNT  (SLOTS),
        .FRAME_EVENTS(FRAME_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_event_type   (i_event_type),
        .i_event_code   (i_event_code),
        .i_event_value  (i_event_value),
        .i_time_seconds (i_time_seconds),
        .i_time_micro   (i_time_micro),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_out_type     (o_out_type),
        .o_out_code     (o_out_code),
        .o_out_value    (o_out_value),
        .o_out_seconds  (o_out_seconds),
        .o_out_micro    (o_out_micro),
        .o_last_in_frame(o_last_in_frame)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    function automatic bit in_calm_stretch();
        return events_taken >= CALM_FROM && events_taken < CALM_TO;
    endfunction

    // Update contact marks for one accepted request and queue any replayed frame.
    function automatic void predict_frame_event(input touch_event_t ev);
        int unsigned s;
        bit          ghost;
        s = slot_ptr;
        ghost = 1'b0;
        last_replay_count = 0;
        if (ev.ev_type == TYPE_ABS) begin
            case (ev.ev_code)
                CODE_SLOT: begin
                    slot_ptr = (ev.ev_value < SLOTS) ? ev.ev_value : 0;
                end
                CODE_TRACK: begin
                    if (ev.ev_value == TRACK_LIFT) begin
                        contact_active[s]  = 1'b0;
                        contact_located[s] = 1'b0;
                    end else begin
                        contact_active[s] = 1'b1;
                    end
                end
                CODE_X: begin
                    x_this_frame[s] = 1'b1;
                    if (y_this_frame[s]) contact_located[s] = 1'b1;
                end
                CODE_Y: begin
                    y_this_frame[s] = 1'b1;
                    if (x_this_frame[s]) contact_located[s] = 1'b1;
                end
                CODE_TMAJOR, CODE_WMAJOR, CODE_PRESS: begin
                    contact_pressed[s] = 1'b1;
                end
                default: ;
            endcase
        end
        if (frame_store.size() < FRAME_DEPTH) frame_store.push_back(ev);
        if (ev.ev_type == TYPE_SYN && ev.ev_code == CODE_REPORT) begin
            for (int k = 0; k < SLOTS; k++) begin
                if (contact_active[k] && contact_pressed[k] && !contact_located[k]) ghost = 1'b1;
            end
            if (!ghost) begin
                last_replay_count = frame_store.size();
                foreach (frame_store[k]) begin
                    replay_expect.push_back('{frame_store[k], k == frame_store.size() - 1});
                end
            end
            for (int k = 0; k < SLOTS; k++) begin
                contact_pressed[k] = 1'b0;
                x_this_frame[k]    = 1'b0;
                y_this_frame[k]    = 1'b0;
            end
            frame_store.delete();
        end
    endfunction

    function automatic touch_event_t make_event(input logic [15:0] ev_type,
                                                input logic [15:0] ev_code,
                                                input logic [31:0] ev_value);
        return '{ev_type, ev_code, ev_value, 32'($urandom), 20'($urandom)};
    endfunction

    // Offer one request from a falling edge, hold it until taken, return at the next falling edge.
    task automatic drive_event(input touch_event_t ev);
        while (!in_calm_stretch() && $urandom_range(0, 99) < 6) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push         <= 1'b1;
        i_event_type   <= ev.ev_type;
        i_event_code   <= ev.ev_code;
        i_event_value  <= ev.ev_value;
        i_time_seconds <= ev.secs;
        i_time_micro   <= ev.micro;
        do @(posedge i_clk); while (o_full);
        predict_frame_event(ev);
        events_taken++;
        @(negedge i_clk);
    endtask

    task automatic send_random_frame();
        int          contacts;
        int          r;
        logic [31:0] slot_val;
        logic [15:0] press_code;
        bit          press_first;
        contacts = $urandom_range(1, 3);
        for (int c = 0; c < contacts; c++) begin
            r = $urandom_range(0, 99);
            if (r < 85) slot_val = $urandom_range(0, SLOTS - 1);
            else if (r < 90) slot_val = SLOTS;
            else if (r < 95) slot_val = 32'hffff_ffff;
            else slot_val = $urandom;
            drive_event(make_event(TYPE_ABS, CODE_SLOT, slot_val));
            r = $urandom_range(0, 99);
            if (r < 12) drive_event(make_event(TYPE_ABS, CODE_TRACK, TRACK_LIFT));
            else if (r < 60) drive_event(make_event(TYPE_ABS, CODE_TRACK, $urandom));
            r = $urandom_range(0, 2);
            press_code = (r == 0) ? CODE_TMAJOR : (r == 1) ? CODE_WMAJOR : CODE_PRESS;
            press_first = $urandom_range(0, 99) < 30;
            if (press_first && $urandom_range(0, 99) < 70) begin
                drive_event(make_event(TYPE_ABS, press_code, $urandom));
            end
            if ($urandom_range(0, 99) < 85) drive_event(make_event(TYPE_ABS, CODE_X, $urandom));
            if ($urandom_range(0, 99) < 85) drive_event(make_event(TYPE_ABS, CODE_Y, $urandom));
            if (!press_first && $urandom_range(0, 99) < 70) begin
                drive_event(make_event(TYPE_ABS, press_code, $urandom));
            end
        end
        // pad now and then toward or past the buffer depth so the report itself may be lost
        if ($urandom_range(0, 99) < 4) begin
            repeat ($urandom_range(55, 75)) begin
                r = $urandom_range(0, 3);
                if (r == 0) drive_event(make_event(TYPE_ABS, CODE_OTHER, $urandom));
                else drive_event(make_event(TYPE_ABS, r == 1 ? CODE_X : CODE_Y, $urandom));
            end
        end
        if ($urandom_range(0, 99) < 92) drive_event(make_event(TYPE_SYN, CODE_REPORT, $urandom));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (replay_expect.size() == 0) begin
                note_mismatch($sformatf("result %h/%h with nothing expected",
                                        o_out_type, o_out_code));
            end else begin
                want = replay_expect.pop_front();
                if (o_out_type !== want.ev.ev_type)
                    note_mismatch($sformatf("type %h, want %h", o_out_type, want.ev.ev_type));
                if (o_out_code !== want.ev.ev_code)
                    note_mismatch($sformatf("code %h, want %h", o_out_code, want.ev.ev_code));
                if (o_out_value !== want.ev.ev_value)
                    note_mismatch($sformatf("value %h, want %h", o_out_value, want.ev.ev_value));
                if (o_out_seconds !== want.ev.secs)
                    note_mismatch($sformatf("seconds %h, want %h", o_out_seconds, want.ev.secs));
                if (o_out_micro !== want.ev.micro)
                    note_mismatch($sformatf("micro %h, want %h", o_out_micro, want.ev.micro));
                if (o_last_in_frame !== want.last)
                    note_mismatch($sformatf("last %b, want %b", o_last_in_frame, want.last));
            end
        end
    end

    // Receiver: random pops, one long hold-off so the block backs up and raises full.
    initial begin
        bit held;
        i_pop = 1'b0;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && events_taken >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                i_pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            i_pop <= in_calm_stretch() || ($urandom_range(0, 99) >= 6);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_touch_ghost_frame_filter: FAIL");
        $finish;
    end

    initial begin
        directed_row_t row;
        mismatches     = 0;
        events_taken   = 0;
        slot_ptr       = 0;
        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_event_type   = '0;
        i_event_code   = '0;
        i_event_value  = '0;
        i_time_seconds = '0;
        i_time_micro   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steer_table[k]) begin
            row = steer_table[k];
            drive_event('{row.ev_type, row.ev_code, row.ev_value, row.secs, row.micro});
            if (row.replay_n != BY_PREDICTOR && last_replay_count != int'(row.replay_n))
                note_mismatch($sformatf("table row %0d replays %0d, want %0d",
                                        k, last_replay_count, row.replay_n));
        end

        while (events_taken < $size(steer_table) + RANDOM_EVENTS) begin
            if ($urandom_range(0, 99) < 80) begin
                send_random_frame();
            end else begin
                drive_event(make_event(16'($urandom), 16'($urandom), $urandom));
            end
        end
        i_push <= 1'b0;

        while (replay_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_touch_ghost_frame_filter: PASS");
        end else begin
            $display("tb_touch_ghost_frame_filter: FAIL");
        end
        $finish;
    end

endmodule
